// File: rtl/idset_pkg.sv
// Package with shared types, codes and constants of the id set allocator.
`default_nettype none

package idset_pkg;

    // Default trie depth and width of the configuration register.
    localparam int MAX_BITS_DEF = 10;
    localparam int NB_RESET     = 10;
    localparam int CFG_W        = 4;
    localparam int NUMBER_W     = 10;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_FIND   = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT,
        S_LEAF,
        S_UP,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [NUMBER_W-1:0] number;
    } t_in;

    typedef struct packed {
        logic [1:0]          status;
        logic [NUMBER_W-1:0] result_number;
        logic                set_empty;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       clr_restart;
        logic       clr_write;
        logic       load;
        logic       read_leaf;
        logic       set_status;
        t_status    status_val;
        logic       mark;
        logic       up_step;
        logic       walk_start;
        logic       walk_step;
        logic       take_x;
        logic       emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       rd_bit;
        logic       lvl_zero;
        logic       lvl_last;
        logic       clr_last;
        logic       out_free;
        logic [1:0] req;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/idset_ram.sv
// Generic simple dual port RAM with registered read.
`default_nettype none

module idset_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/idset_ctrl.sv
// Controller state machine that sequences clear, update and search steps.
`default_nettype none

module idset_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_in_req,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_valid,
    input  wire idset_pkg::t_stat  i_stat,
    output idset_pkg::t_cmd        o_cmd,
    output logic                   o_in_stall
);
    import idset_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_fire;

    assign o_in_stall = (r_state != S_IDLE) || i_cfg_valid;
    assign in_fire    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.load = 1'b1;
                    case (i_in_req)
                        REQ_INSERT, REQ_REMOVE: n_state = S_LEAF;
                        REQ_FIND:               n_state = S_ROOT;
                        default:                n_state = S_DONE;
                    endcase
                end
            end
            S_ROOT: begin
                if (i_stat.rd_bit) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status_val = ST_FULL;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.read_leaf = 1'b1;
                    n_state         = S_LEAF;
                end
            end
            S_LEAF: begin
                case (i_stat.req)
                    REQ_INSERT: begin
                        if (i_stat.rd_bit) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status_val = ST_PRESENT;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.mark = 1'b1;
                            n_state    = S_UP;
                        end
                    end
                    REQ_REMOVE: begin
                        if (!i_stat.rd_bit) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status_val = ST_ABSENT;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.mark = 1'b1;
                            n_state    = S_UP;
                        end
                    end
                    REQ_FIND: begin
                        if (!i_stat.rd_bit) begin
                            o_cmd.take_x = 1'b1;
                            n_state      = S_DONE;
                        end else begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = S_WALK;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_UP: begin
                o_cmd.up_step = 1'b1;
                if (i_stat.lvl_zero) begin
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.lvl_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase

        // A configuration write reshapes the tree, so the set is cleared.
        if (i_cfg_we) begin
            o_cmd             = '0;
            o_cmd.clr_restart = 1'b1;
            n_state           = S_CLEAR;
        end
    end

endmodule

`default_nettype wire

// File: rtl/idset_dp.sv
// Datapath with the full mark memory, operand, walk and output registers.
`default_nettype none

module idset_dp #(
    parameter int MAX_BITS = idset_pkg::MAX_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire idset_pkg::t_in               i_in,
    input  wire logic                         i_cfg_we,
    input  wire logic [idset_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire idset_pkg::t_cmd              i_cmd,
    output idset_pkg::t_stat                  o_stat,
    input  wire logic                         i_out_stall,
    output logic                              o_out_valid,
    output idset_pkg::t_out                   o_out
);
    import idset_pkg::*;

    localparam int AW      = MAX_BITS + 1;
    localparam int DEPTH   = (2 << MAX_BITS) - 1;
    localparam int LW      = $clog2(MAX_BITS + 1);
    localparam int NB_INIT = (NB_RESET > MAX_BITS) ? MAX_BITS : NB_RESET;

    function automatic logic [AW-1:0] f_node(input logic [LW-1:0] lvl,
                                             input logic [MAX_BITS-1:0] p);
        f_node = ((AW'(1) << lvl) - AW'(1)) + AW'(p);
    endfunction

    function automatic logic [MAX_BITS-1:0] f_mask(input logic [LW-1:0] lvl);
        f_mask = (MAX_BITS'(1) << lvl) - MAX_BITS'(1);
    endfunction

    function automatic logic [MAX_BITS-1:0] f_bit(input logic [LW-1:0] lvl);
        f_bit = MAX_BITS'(1) << lvl;
    endfunction

    logic [LW-1:0]       r_nb;
    logic [1:0]          r_req;
    logic [MAX_BITS-1:0] r_x;
    logic [LW-1:0]       r_lvl;
    logic                r_pathval;
    logic [MAX_BITS-1:0] r_result;
    t_status             r_status;
    logic [AW-1:0]       r_total;
    logic [AW-1:0]       r_clr_addr;
    logic                r_out_valid;
    t_out                r_out;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic                ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic                ram_rdata;

    logic [31:0]         num_wide;
    logic [MAX_BITS-1:0] x_in;
    logic [LW-1:0]       lvl_dn;
    logic [LW-1:0]       lvl_up;
    logic [LW-1:0]       lvl_up2;
    logic                up_val;
    logic                walk_b;
    logic [MAX_BITS-1:0] walk_res;
    logic [31:0]         res_wide;
    logic [LW-1:0]       cfg_nb;
    logic                out_free;

    assign num_wide = 32'(i_in.number);
    assign x_in     = num_wide[MAX_BITS-1:0] & f_mask(r_nb);
    assign lvl_dn   = r_lvl - LW'(1);
    assign lvl_up   = r_lvl + LW'(1);
    assign lvl_up2  = r_lvl + LW'(2);
    assign up_val   = r_pathval & ram_rdata;
    assign walk_b   = ((r_x & f_bit(r_lvl)) != '0) ^ ram_rdata;
    assign walk_res = r_result | (walk_b ? f_bit(r_lvl) : '0);
    assign res_wide = 32'(r_result);
    assign out_free = !r_out_valid || !i_out_stall;

    // Out of range widths are clamped to the supported span.
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_nb = LW'(1);
        end else if (32'(i_cfg_data) > MAX_BITS) begin
            cfg_nb = LW'(MAX_BITS);
        end else begin
            cfg_nb = LW'(i_cfg_data);
        end
    end

    // Memory port selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (i_cmd.clr_write) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
        end
        if (i_cmd.load) begin
            ram_re    = 1'b1;
            ram_raddr = (i_in.req_type == REQ_FIND) ? '0 : f_node(r_nb, x_in);
        end
        if (i_cmd.read_leaf) begin
            ram_re    = 1'b1;
            ram_raddr = f_node(r_nb, r_x);
        end
        if (i_cmd.mark) begin
            ram_we    = 1'b1;
            ram_waddr = f_node(r_nb, r_x);
            ram_wdata = (r_req == REQ_INSERT);
            ram_re    = 1'b1;
            ram_raddr = f_node(r_nb, r_x ^ f_bit(r_nb - LW'(1)));
        end
        if (i_cmd.up_step) begin
            ram_we    = 1'b1;
            ram_waddr = f_node(r_lvl, r_x & f_mask(r_lvl));
            ram_wdata = up_val;
            ram_re    = (r_lvl != '0);
            ram_raddr = f_node(r_lvl, (r_x & f_mask(r_lvl)) ^ f_bit(lvl_dn));
        end
        if (i_cmd.walk_start) begin
            ram_re    = 1'b1;
            ram_raddr = f_node(LW'(1), r_x & f_bit('0));
        end
        if (i_cmd.walk_step) begin
            ram_re    = (lvl_up != r_nb);
            ram_raddr = f_node(lvl_up2, walk_res | (r_x & f_bit(lvl_up)));
        end
    end

    idset_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb        <= LW'(NB_INIT);
            r_total     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_nb <= cfg_nb;
            end
            if (i_cmd.clr_restart) begin
                r_clr_addr <= '0;
                r_total    <= '0;
            end else if (i_cmd.clr_write) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.mark) begin
                r_total <= (r_req == REQ_INSERT) ? r_total + AW'(1) : r_total - AW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Operand, walk and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_in.req_type;
            r_x      <= x_in;
            r_result <= '0;
            r_status <= ST_OK;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_val;
        end
        if (i_cmd.mark) begin
            r_pathval <= (r_req == REQ_INSERT);
            r_lvl     <= r_nb - LW'(1);
        end
        if (i_cmd.up_step) begin
            r_pathval <= up_val;
            r_lvl     <= lvl_dn;
        end
        if (i_cmd.take_x) begin
            r_result <= r_x;
        end
        if (i_cmd.walk_start) begin
            r_result <= '0;
            r_lvl    <= '0;
        end
        if (i_cmd.walk_step) begin
            r_result <= walk_res;
            r_lvl    <= lvl_up;
        end
        if (i_cmd.emit) begin
            r_out.status        <= r_status;
            r_out.result_number <= res_wide[NUMBER_W-1:0];
            r_out.set_empty     <= (r_total == '0);
        end
    end

    assign o_stat.rd_bit   = ram_rdata;
    assign o_stat.lvl_zero = (r_lvl == '0);
    assign o_stat.lvl_last = (lvl_up == r_nb);
    assign o_stat.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_stat.out_free = out_free;
    assign o_stat.req      = r_req;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// File: rtl/id_set_with_next_free.sv
// Top level of the id set allocator: a number set with next unused search.
// Insert and remove end after the leaf read if the set does not change, else they
// climb the trie to the root. Find ends after the root read (set full), the leaf
// read (number unused) or a walk down the nb levels of the configured width. One
// request is in work at a time: a new one is taken only once the previous result
// is registered and the controller is idle again. Reset and every configuration write
// clear the set in a pass over all 2^(MAX_BITS+1)-1 mark nodes, taking no request.
`default_nettype none

module id_set_with_next_free #(
    parameter int MAX_BITS = idset_pkg::MAX_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire idset_pkg::t_in               i_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output idset_pkg::t_out                   o_out,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [idset_pkg::CFG_W-1:0]  i_cfg_data
);
    import idset_pkg::*;

    // The set is held as one full mark per node of a binary trie. Leaves are
    // the presence bits of the numbers; an inner node is marked full when both
    // of its children are. Level i of the trie branches on bit i of a number,
    // least significant bit first. All marks live in a one bit wide memory
    // with one write and one registered read port.
    //
    // Insert and remove first read the leaf. On a change they write the leaf
    // and then climb to the root, one level per cycle: the sibling mark read
    // in the previous cycle is combined with the new path mark and written
    // back while the next sibling read is issued.
    //
    // Find reads the root first (full set), then the leaf (the number itself
    // is unused). Otherwise it walks down one level per cycle, following the
    // number's bit unless that child is full, and building the result from
    // the branches taken.

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_we;

    // The register port is always ready; a write reshapes the trie and
    // starts a fresh clearing pass.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    idset_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in.req_type),
        .i_cfg_we    (cfg_we),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    // The datapath holds the result register, so a finished result can wait
    // for its transfer while the controller returns to idle.
    idset_dp #(
        .MAX_BITS (MAX_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
